>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the positional array table.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define PAT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pat_checker: property failed");

// Next-cycle implication, disabled while reset is low
`define PAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pat_checker: property failed");

`endif

>>> hdl/pat_pkg.sv
// Shared constants, types and helpers for the positional array table.
// No dependencies; used by every module of the block.
package pat_pkg;

  // Table geometry
  localparam int unsigned DEPTH  = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned GRP_W  = 8;
  localparam int unsigned NGROUP = (DEPTH + GRP_W - 1) / GRP_W;
  localparam int unsigned MASK_N = (DEPTH < 32) ? DEPTH : 32;
  localparam int unsigned GCNT_W = $clog2(GRP_W + 1);
  localparam int unsigned GOFF_W = $clog2(GRP_W);

  // Operation codes
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BADPOS   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Command broadcast along the row of cells
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] count;
    logic [31:0]      value;
  } cell_cmd_t;

  // Side information travelling with a word through the tally stages
  typedef struct packed {
    logic             search;
    logic [1:0]       status;
    logic [CNT_W-1:0] held;
  } side_t;

  // Clamp a count to the 6-bit result fields
  function automatic logic [5:0] sat6(input logic [CNT_W-1:0] v);
    logic [CNT_W+6:0] wide;
    wide = (CNT_W + 7)'(v);
    if (wide > (CNT_W + 7)'(63)) begin
      return 6'd63;
    end
    return wide[5:0];
  endfunction

endpackage

>>> hdl/positional_array_table.sv
// Top level of the positional array table: command decode, entry count, cell row.
// Depends on pat_pkg, pat_cell and pat_tally.
//
// Use: drive kind_i, position_i and value_i with start_i high; the word is
// taken at any rising edge where start_i is high and busy_o is low. busy_o
// stays low, so a new word may be issued in every cycle.
// Insert (1-based position 1..count+1) shifts later entries up, delete
// (1..count) shifts them down, search compares every held entry with value_i.
// Each word gives exactly one result, shown for one cycle with done_o high,
// after the cell and stage-1 registers, the stage A register and the result
// register have taken it in turn. Results come out in issue order.
// Throughput: one word per cycle. The row of cells shifts or compares all
// slots in the accepting cycle; the count and first position are reduced in
// two registered stages behind it.
// Reset (rst_ni low, asynchronous) empties the table and drops words in
// flight; entry contents are not cleared. The receiver cannot stall: every
// result is taken in the cycle it is shown.
module positional_array_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         kind_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [5:0]         first_match_res_o,
  output logic [5:0]         match_count_o,
  output logic [31:0]        match_mask_o,
  output logic [5:0]         entries_held_o
);

  localparam int unsigned CMP_W = ((pat_pkg::CNT_W > 6) ? pat_pkg::CNT_W : 6) + 1;

  logic                       accept;
  logic [pat_pkg::CNT_W-1:0]  count_q, count_nx;
  logic [CMP_W-1:0]           pos_w, cnt_w;
  logic [5:0]                 pos_m1;
  logic                       ins_ok, del_ok;
  logic [1:0]                 status;
  pat_pkg::cell_cmd_t         cmd;
  pat_pkg::side_t             side;

  logic                       s1_vld_q;
  pat_pkg::side_t             s1_side_q;

  logic [31:0]                cell_data [pat_pkg::DEPTH];
  logic [pat_pkg::DEPTH-1:0]  match;

  // Every cycle can take a word
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign pos_w  = CMP_W'(position_i);
  assign cnt_w  = CMP_W'(count_q);
  assign pos_m1 = position_i - 6'd1;

  // Decode: range checks and next entry count
  always_comb begin
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    status   = pat_pkg::ST_OK;
    count_nx = count_q;
    case (kind_i)
      pat_pkg::KIND_INSERT: begin
        if (count_q == pat_pkg::CNT_W'(pat_pkg::DEPTH)) begin
          status = pat_pkg::ST_FULL;
        end else if ((position_i == 6'd0) || (pos_w > cnt_w + CMP_W'(1))) begin
          status = pat_pkg::ST_BADPOS;
        end else begin
          ins_ok   = 1'b1;
          count_nx = count_q + pat_pkg::CNT_W'(1);
        end
      end
      pat_pkg::KIND_DELETE: begin
        if ((position_i == 6'd0) || (pos_w > cnt_w)) begin
          status = pat_pkg::ST_BADPOS;
        end else begin
          del_ok   = 1'b1;
          count_nx = count_q - pat_pkg::CNT_W'(1);
        end
      end
      default: begin
        status = pat_pkg::ST_OK;
      end
    endcase
  end

  // Broadcast to the cells
  always_comb begin
    cmd.ins   = accept && ins_ok;
    cmd.del   = accept && del_ok;
    cmd.slot  = pat_pkg::IDX_W'(pos_m1);
    cmd.count = count_q;
    cmd.value = $unsigned(value_i);
    side.search = (kind_i == pat_pkg::KIND_SEARCH);
    side.status = status;
    side.held   = count_nx;
  end

  // Entry count and first pipeline stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      if (accept) begin
        count_q <= count_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q <= side;
  end

  // Row of cells, each wired to its neighbours
  for (genvar i = 0; i < pat_pkg::DEPTH; i++) begin : g_cell
    logic [31:0] left, right;
    if (i == 0) begin : g_first
      assign left = cmd.value;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == pat_pkg::DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    pat_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (pat_pkg::IDX_W'(i)),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .match_o (match[i])
    );
  end

  pat_tally u_tally (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .vld_i             (s1_vld_q),
    .side_i            (s1_side_q),
    .match_i           (match),
    .done_o            (done_o),
    .status_o          (status_o),
    .first_match_res_o (first_match_res_o),
    .match_count_o     (match_count_o),
    .match_mask_o      (match_mask_o),
    .entries_held_o    (entries_held_o)
  );

endmodule

>>> hdl/pat_cell.sv
// One slot of the table: holds an entry, shifts with its neighbours, compares.
// Depends on pat_pkg.
module pat_cell (
  input  logic                    clk_i,
  input  logic [pat_pkg::IDX_W-1:0] idx_i,
  input  pat_pkg::cell_cmd_t      cmd_i,
  input  logic [31:0]             left_i,
  input  logic [31:0]             right_i,
  output logic [31:0]             data_o,
  output logic                    match_o
);

  logic [31:0] data_q, data_d;
  logic        match_q, match_d;

  // Insert: own slot loads the value, slots above take the left word.
  // Delete: own slot and those above take the right word.
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx_i == cmd_i.slot) begin
        data_d = cmd_i.value;
      end else if (idx_i > cmd_i.slot) begin
        data_d = left_i;
      end
    end else if (cmd_i.del && (idx_i >= cmd_i.slot)) begin
      data_d = right_i;
    end
  end

  // Compare only slots that hold an entry
  assign match_d = (pat_pkg::CNT_W'(idx_i) < cmd_i.count) && (data_q == cmd_i.value);

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

>>> hdl/pat_tally.sv
// Two-stage reduction of the cell match bits into first position, count and mask,
// plus the registered result word. Depends on pat_pkg.
module pat_tally (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  pat_pkg::side_t            side_i,
  input  logic [pat_pkg::DEPTH-1:0] match_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic [5:0]                first_match_res_o,
  output logic [5:0]                match_count_o,
  output logic [31:0]               match_mask_o,
  output logic [5:0]                entries_held_o
);

  localparam int unsigned PAD_W = pat_pkg::NGROUP * pat_pkg::GRP_W;

  logic [PAD_W-1:0]          padded;
  logic [pat_pkg::GCNT_W-1:0] gcnt_d [pat_pkg::NGROUP];
  logic [pat_pkg::GOFF_W-1:0] goff_d [pat_pkg::NGROUP];
  logic [pat_pkg::NGROUP-1:0] gany_d;
  logic [31:0]               mask_d;

  logic                      a_vld_q;
  pat_pkg::side_t            a_side_q;
  logic [31:0]               a_mask_q;
  logic [pat_pkg::GCNT_W-1:0] a_gcnt_q [pat_pkg::NGROUP];
  logic [pat_pkg::GOFF_W-1:0] a_goff_q [pat_pkg::NGROUP];
  logic [pat_pkg::NGROUP-1:0] a_gany_q;

  logic [pat_pkg::CNT_W-1:0] total;
  logic [pat_pkg::CNT_W-1:0] first;

  logic       done_q;
  logic [1:0] status_q;
  logic [5:0] first_q, count_q, held_q;
  logic [31:0] mask_q;

  // Stage A: per-group popcount and lowest set bit
  assign padded = PAD_W'(match_i);

  always_comb begin
    for (int g = 0; g < pat_pkg::NGROUP; g++) begin
      gcnt_d[g] = '0;
      goff_d[g] = '0;
      gany_d[g] = 1'b0;
      for (int b = pat_pkg::GRP_W - 1; b >= 0; b--) begin
        if (padded[g*pat_pkg::GRP_W + b]) begin
          goff_d[g] = pat_pkg::GOFF_W'(b);
          gany_d[g] = 1'b1;
          gcnt_d[g] = gcnt_d[g] + pat_pkg::GCNT_W'(1);
        end
      end
    end
  end

  // Mask covers the first 32 positions only
  always_comb begin
    mask_d = '0;
    mask_d[pat_pkg::MASK_N-1:0] = match_i[pat_pkg::MASK_N-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_side_q <= side_i;
    a_mask_q <= mask_d;
    a_gcnt_q <= gcnt_d;
    a_goff_q <= goff_d;
    a_gany_q <= gany_d;
  end

  // Stage B: add the group counts, pick the lowest group with a hit
  always_comb begin
    total = '0;
    first = '0;
    for (int g = 0; g < pat_pkg::NGROUP; g++) begin
      total = total + pat_pkg::CNT_W'(a_gcnt_q[g]);
    end
    for (int g = pat_pkg::NGROUP - 1; g >= 0; g--) begin
      if (a_gany_q[g]) begin
        first = pat_pkg::CNT_W'(g * pat_pkg::GRP_W) + pat_pkg::CNT_W'(a_goff_q[g])
              + pat_pkg::CNT_W'(1);
      end
    end
  end

  // Result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= pat_pkg::sat6(a_side_q.held);
    if (a_side_q.search) begin
      status_q <= (total == '0) ? pat_pkg::ST_NOTFOUND : pat_pkg::ST_OK;
      first_q  <= pat_pkg::sat6(first);
      count_q  <= pat_pkg::sat6(total);
      mask_q   <= a_mask_q;
    end else begin
      status_q <= a_side_q.status;
      first_q  <= '0;
      count_q  <= '0;
      mask_q   <= '0;
    end
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign first_match_res_o = first_q;
  assign match_count_o     = count_q;
  assign match_mask_o      = mask_q;
  assign entries_held_o    = held_q;

endmodule

>>> hdl/pat_checker.sv
// Port-level checks for the positional array table, bound to the top level.
// Depends on pat_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [5:0]  first_match_res_o,
  input logic [5:0]  match_count_o,
  input logic [31:0] match_mask_o,
  input logic [5:0]  entries_held_o
);

  logic accepted;
  assign accepted = start_i && !busy_o;

  // Every accepted word gives a result
  `PAT_ASSERT_SAME(a_result_follows, clk_i, rst_ni, accepted, ##3 done_o)

  // No result without an accepted word before it
  `PAT_ASSERT_SAME(a_no_spurious, clk_i, rst_ni, done_o, $past(accepted, 3))

  // A miss reports nothing else
  `PAT_ASSERT_SAME(a_miss_clean, clk_i, rst_ni,
    done_o && (status_o == pat_pkg::ST_NOTFOUND),
    (first_match_res_o == 6'd0) && (match_count_o == 6'd0) && (match_mask_o == 32'd0))

  // A hit has a first position and ok status
  `PAT_ASSERT_SAME(a_hit_first, clk_i, rst_ni, done_o && (match_count_o != 6'd0),
    (first_match_res_o != 6'd0) && (status_o == pat_pkg::ST_OK))

  // Matches never exceed the entries held
  `PAT_ASSERT_SAME(a_count_bound, clk_i, rst_ni, done_o, match_count_o <= entries_held_o)

endmodule

bind positional_array_table pat_checker u_pat_checker (.*);

>>> sim/positional_array_table_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_array_table: insert, delete and search words.
// Depends on pat_pkg and the positional_array_table RTL; reads no files.
module positional_array_table_test;

  localparam int CLK_PERIOD = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int WORD_TARGET = 1300;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  position;
    logic [31:0] value;
  } table_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  first_pos;
    logic [5:0]  hits;
    logic [31:0] hit_mask;
    logic [5:0]  held;
  } table_result_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_CHURN} mix_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         kind_i = pat_pkg::KIND_SEARCH;
  logic [5:0]         position_i = 6'd0;
  logic signed [31:0] value_i = 32'sd0;
  logic               done_o;
  logic [1:0]         status_o;
  logic [5:0]         first_match_res_o;
  logic [5:0]         match_count_o;
  logic [31:0]        match_mask_o;
  logic [5:0]         entries_held_o;

  // Words still to issue and results still owed by the block
  table_op_t     ops_to_issue[$];
  table_result_t results_due[$];

  // Predicted table contents
  logic [31:0] table_vals[pat_pkg::DEPTH];
  int          table_count = 0;

  // Stimulus planning state
  int          plan_count = 0;
  logic [31:0] value_pool[8];
  int          idle_left = 0;
  int          steady_left = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  positional_array_table DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .kind_i            (kind_i),
    .position_i        (position_i),
    .value_i           (value_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .first_match_res_o (first_match_res_o),
    .match_count_o     (match_count_o),
    .match_mask_o      (match_mask_o),
    .entries_held_o    (entries_held_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [5:0] clip_to_6(int v);
    return (v > 63) ? 6'd63 : 6'(v);
  endfunction

  // Apply one word to the predicted table and work out its result
  function automatic table_result_t predict_table_op(table_op_t op);
    table_result_t res;
    int            pos;
    int            hits;
    int            first;
    res = '0;
    res.status = pat_pkg::ST_OK;
    pos = int'(op.position);
    hits = 0;
    first = 0;
    case (op.kind)
      pat_pkg::KIND_INSERT: begin
        if (table_count >= pat_pkg::DEPTH) begin
          res.status = pat_pkg::ST_FULL;
        end else if (pos < 1 || pos > table_count + 1) begin
          res.status = pat_pkg::ST_BADPOS;
        end else begin
          for (int i = table_count; i >= pos; i--) table_vals[i] = table_vals[i - 1];
          table_vals[pos - 1] = op.value;
          table_count++;
        end
      end
      pat_pkg::KIND_DELETE: begin
        if (pos < 1 || pos > table_count) begin
          res.status = pat_pkg::ST_BADPOS;
        end else begin
          for (int i = pos; i < table_count; i++) table_vals[i - 1] = table_vals[i];
          table_count--;
        end
      end
      pat_pkg::KIND_SEARCH: begin
        for (int i = 0; i < table_count; i++) begin
          if (table_vals[i] == op.value) begin
            if (hits == 0) first = i + 1;
            hits++;
            if (i < 32) res.hit_mask[i] = 1'b1;
          end
        end
        if (hits == 0) res.status = pat_pkg::ST_NOTFOUND;
      end
      default: ;  // unused kind: table untouched
    endcase
    res.first_pos = clip_to_6(first);
    res.hits = clip_to_6(hits);
    res.held = clip_to_6(table_count);
    return res;
  endfunction

  // Queue a word and track the entry count it leaves behind
  task automatic add_op(logic [1:0] kind, logic [5:0] pos, logic [31:0] value);
    table_op_t op;
    op.kind = kind;
    op.position = pos;
    op.value = value;
    ops_to_issue.push_back(op);
    if (kind == pat_pkg::KIND_INSERT && plan_count < pat_pkg::DEPTH && pos >= 1 &&
        pos <= plan_count + 1) begin
      plan_count++;
    end else if (kind == pat_pkg::KIND_DELETE && pos >= 1 && pos <= plan_count) begin
      plan_count--;
    end
  endtask

  // Values mostly from a small pool so that searches find repeats
  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 55) return value_pool[3'($urandom_range(7))];
    return $urandom();
  endfunction

  task automatic add_random_op(mix_e mix);
    int         r;
    int         ins_pct;
    int         del_pct;
    logic [5:0] pos;
    r = $urandom_range(99);
    // noise: any kind, any position, any value
    if (r < 8) begin
      add_op(2'($urandom_range(3)), 6'($urandom_range(63)), $urandom());
      return;
    end
    case (mix)
      MIX_FILL:  begin ins_pct = 70; del_pct = 15; end
      MIX_DRAIN: begin ins_pct = 15; del_pct = 65; end
      default:   begin ins_pct = 40; del_pct = 35; end
    endcase
    r = $urandom_range(99);
    if (r < ins_pct) begin
      if ($urandom_range(99) < 88) pos = 6'($urandom_range(plan_count + 1, 1));
      else pos = 6'($urandom_range(63));
      add_op(pat_pkg::KIND_INSERT, pos, pick_value());
    end else if (r < ins_pct + del_pct) begin
      if (plan_count > 0 && $urandom_range(99) < 88) pos = 6'($urandom_range(plan_count, 1));
      else pos = 6'($urandom_range(63));
      add_op(pat_pkg::KIND_DELETE, pos, pick_value());
    end else begin
      add_op(pat_pkg::KIND_SEARCH, 6'($urandom_range(63)), pick_value());
    end
  endtask

  // Idle cycles after a word: mostly none, some short, a few long,
  // with occasional stretches of back-to-back words
  function automatic int draw_idle();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) begin
      steady_left = $urandom_range(60, 20);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Driver: predicts each accepted word, then presents the next or idles
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    table_op_t taken;
    table_op_t next_op;
    if (!rst_ni) begin
      start_i <= 1'b0;
      kind_i <= pat_pkg::KIND_SEARCH;
      position_i <= 6'd0;
      value_i <= 32'sd0;
    end else begin
      if (start_i && !busy_o) begin
        taken.kind = kind_i;
        taken.position = position_i;
        taken.value = value_i;
        results_due.push_back(predict_table_op(taken));
        idle_left = draw_idle();
      end
      if (!(start_i && busy_o)) begin
        if (idle_left > 0) begin
          idle_left--;
          start_i <= 1'b0;
        end else if (ops_to_issue.size() > 0) begin
          next_op = ops_to_issue.pop_front();
          kind_i <= next_op.kind;
          position_i <= next_op.position;
          value_i <= next_op.value;
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result against the oldest expectation
  always @(posedge clk_i) begin : check_results
    table_result_t want;
    if (rst_ni && done_o) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0h", $time, status_o);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("first_match_res", 32'(want.first_pos), 32'(first_match_res_o));
        check_field("match_count", 32'(want.hits), 32'(match_count_o));
        check_field("match_mask", want.hit_mask, match_mask_o);
        check_field("entries_held", 32'(want.held), 32'(entries_held_o));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("positional_array_table_test failed");
    $finish;
  end

  initial begin
    mix_e mix;
    value_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0, 32'h0, 32'h0, 32'h0};
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom();

    // Directed: empty table, bad positions, ends and middle, extremes
    add_op(pat_pkg::KIND_SEARCH, 6'd0, 32'h0000_0000);
    add_op(pat_pkg::KIND_DELETE, 6'd1, 32'h0000_0000);
    add_op(pat_pkg::KIND_DELETE, 6'd0, 32'h0000_0000);
    add_op(pat_pkg::KIND_INSERT, 6'd0, 32'h1234_5678);
    add_op(pat_pkg::KIND_INSERT, 6'd2, 32'h1234_5678);
    add_op(pat_pkg::KIND_INSERT, 6'd63, 32'hFFFF_FFFF);
    add_op(pat_pkg::KIND_INSERT, 6'd1, 32'h8000_0000);
    add_op(pat_pkg::KIND_INSERT, 6'd2, 32'h7FFF_FFFF);
    add_op(pat_pkg::KIND_INSERT, 6'd1, 32'h7FFF_FFFF);
    add_op(pat_pkg::KIND_INSERT, 6'd2, 32'hFFFF_FFFF);
    add_op(pat_pkg::KIND_SEARCH, 6'd0, 32'h7FFF_FFFF);
    add_op(pat_pkg::KIND_SEARCH, 6'd17, 32'h8000_0000);
    add_op(pat_pkg::KIND_SEARCH, 6'd0, 32'h0000_0000);
    add_op(KIND_UNUSED, 6'd63, 32'hA5A5_5A5A);
    add_op(pat_pkg::KIND_DELETE, 6'd5, 32'h0000_0000);
    add_op(pat_pkg::KIND_DELETE, 6'd4, 32'h0000_0000);
    add_op(pat_pkg::KIND_DELETE, 6'd1, 32'h0000_0000);
    add_op(pat_pkg::KIND_SEARCH, 6'd63, 32'hFFFF_FFFF);
    add_op(pat_pkg::KIND_DELETE, 6'd1, 32'h0000_0000);
    add_op(pat_pkg::KIND_DELETE, 6'd1, 32'h0000_0000);
    add_op(pat_pkg::KIND_DELETE, 6'd1, 32'h0000_0000);
    add_op(pat_pkg::KIND_SEARCH, 6'd0, 32'hFFFF_FFFF);

    // Fill to the top, then push against a full table
    repeat (pat_pkg::DEPTH) begin
      add_op(pat_pkg::KIND_INSERT, 6'($urandom_range(plan_count + 1, 1)), pick_value());
    end
    add_op(pat_pkg::KIND_INSERT, 6'($urandom_range(pat_pkg::DEPTH + 1, 1)), pick_value());
    add_op(pat_pkg::KIND_INSERT, 6'($urandom_range(63)), pick_value());
    repeat (4) add_op(pat_pkg::KIND_SEARCH, 6'($urandom_range(63)), pick_value());

    // Random bursts that swing the count between empty and full
    while (ops_to_issue.size() < WORD_TARGET) begin
      mix = mix_e'($urandom_range(2));
      repeat ($urandom_range(80, 30)) add_random_op(mix);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all words taken, all results in, then a short settle
    while (ops_to_issue.size() != 0 || start_i) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("positional_array_table_test passed");
    end else begin
      $display("positional_array_table_test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/pat_pkg.sv
hdl/pat_cell.sv
hdl/pat_tally.sv
hdl/positional_array_table.sv
hdl/pat_checker.sv
sim/positional_array_table_test.sv
